// ===== hdl/hcbd_pkg.sv =====
package hcbd_pkg;

  // width of the chunk length accumulator
  localparam int LENGTH_BITS = 32;

  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_SP = 8'h20;

  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_DONE    = 2'd1;
  localparam logic [1:0] KIND_ERROR   = 2'd2;

  typedef struct packed {
    logic       valid;
    logic [1:0] kind;
    logic [7:0] payload;
    logic       body_end;
  } hcbd_result_t;

endpackage

// ===== hdl/hcbd_step.sv =====
module hcbd_step import hcbd_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         fire,
  input  logic [7:0]   data_byte,
  output hcbd_result_t res
);

  typedef enum logic [2:0] {
    PH_LEN  = 3'd0,
    PH_EXT  = 3'd1,
    PH_LF1  = 3'd2,
    PH_DATA = 3'd3,
    PH_DCR  = 3'd4,
    PH_DLF  = 3'd5,
    PH_TCR  = 3'd6,
    PH_TLF  = 3'd7
  } phase_t;

  phase_t                   phase;
  phase_t                   phase_next;
  logic [LENGTH_BITS-1:0]   chunk_remaining;
  logic [LENGTH_BITS-1:0]   chunk_remaining_next;
  logic [LENGTH_BITS-1:0]   rem_dec;
  logic [3:0]               digit;
  logic                     overflow;

  function automatic logic [3:0] hex_value(input logic [7:0] ch);
    logic [3:0] v;
    v = 4'd0;
    if (ch >= 8'h30 && ch <= 8'h39) v = ch[3:0];
    else if ((ch >= 8'h61 && ch <= 8'h66) || (ch >= 8'h41 && ch <= 8'h46))
      v = ch[3:0] + 4'd9;
    return v;
  endfunction

  assign digit    = hex_value(data_byte);
  // a shift by one more digit would drop set bits
  assign overflow = chunk_remaining[LENGTH_BITS-1 -: 4] != 4'd0;
  assign rem_dec  = (chunk_remaining != '0) ? chunk_remaining - 1'b1 : chunk_remaining;

  always_comb begin
    phase_next           = phase;
    chunk_remaining_next = chunk_remaining;
    res.valid            = 1'b0;
    res.kind             = KIND_PAYLOAD;
    res.payload          = 8'd0;
    res.body_end         = 1'b0;
    case (phase)
      PH_LEN: begin
        if (data_byte == CH_CR) phase_next = PH_LF1;
        else if (data_byte == CH_SP) phase_next = PH_EXT;
        else if (overflow) begin
          res.valid = 1'b1;
          res.kind  = KIND_ERROR;
          res.body_end = 1'b1;
          chunk_remaining_next = '0;
        end else begin
          chunk_remaining_next = {chunk_remaining[LENGTH_BITS-5:0], digit};
        end
      end
      PH_EXT: begin
        if (data_byte == CH_CR) phase_next = PH_LF1;
      end
      PH_DATA: begin
        chunk_remaining_next = rem_dec;
        if (rem_dec == '0) phase_next = PH_DCR;
        res.valid   = 1'b1;
        res.kind    = KIND_PAYLOAD;
        res.payload = data_byte;
      end
      default: begin
        // delimiter phases: one expected byte each
        if (data_byte != ((phase == PH_DCR || phase == PH_TCR) ? CH_CR : CH_LF)) begin
          res.valid            = 1'b1;
          res.kind             = KIND_ERROR;
          res.body_end         = 1'b1;
          phase_next           = PH_LEN;
          chunk_remaining_next = '0;
        end else begin
          case (phase)
            PH_LF1: phase_next = (chunk_remaining == '0) ? PH_TCR : PH_DATA;
            PH_DCR: phase_next = PH_DLF;
            PH_TCR: phase_next = PH_TLF;
            PH_DLF: begin
              phase_next           = PH_LEN;
              chunk_remaining_next = '0;
            end
            default: begin
              phase_next           = PH_LEN;
              chunk_remaining_next = '0;
              res.valid            = 1'b1;
              res.kind             = KIND_DONE;
              res.body_end         = 1'b1;
            end
          endcase
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_LEN;
      chunk_remaining <= '0;
    end else if (fire) begin
      phase           <= phase_next;
      chunk_remaining <= chunk_remaining_next;
    end
  end

  a_data_nonzero: assert property (@(posedge clk) disable iff (rst)
    phase == PH_DATA |-> chunk_remaining != '0)
    else $error("data phase with zero bytes left");

  a_final_lf: assert property (@(posedge clk) disable iff (rst)
    fire && phase == PH_TLF && data_byte == CH_LF |=> phase == PH_LEN && chunk_remaining == '0)
    else $error("final line did not restart body");

  a_error_clears: assert property (@(posedge clk) disable iff (rst)
    fire && res.valid && res.kind == KIND_ERROR |=> phase == PH_LEN && chunk_remaining == '0)
    else $error("error did not return to length state");

endmodule

// ===== hdl/http_chunked_body_decoder_top.sv =====
// Chunked transfer body decoder: takes one body byte per transaction and, where the
// framing yields one, returns a payload byte, a body-complete marker or a framing error.
// It sustains one byte per clock while results are taken; a byte passes an input
// register, the framing step and a result register. The input side stalls only while
// the result register holds a transaction that has not been taken.
module http_chunked_body_decoder_top import hcbd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       data_valid,
  output logic       data_ready,
  input  logic [7:0] data_byte,
  output logic       result_valid,
  input  logic       result_ready,
  output logic [1:0] result_kind,
  output logic [7:0] payload_byte,
  output logic       body_end
);

  logic         in_valid;
  logic [7:0]   in_byte;
  logic         fire;
  hcbd_result_t res;

  // step the framing state when the result slot can take whatever comes out
  assign fire       = in_valid && (!result_valid || result_ready);
  assign data_ready = !in_valid || fire;

  hcbd_step u_step (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .data_byte (in_byte),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (data_ready) in_valid <= data_valid;
      if (fire && res.valid) result_valid <= 1'b1;
      else if (result_ready) result_valid <= 1'b0;
    end
    if (data_valid && data_ready) in_byte <= data_byte;
    if (fire && res.valid) begin
      result_kind  <= res.kind;
      payload_byte <= res.payload;
      body_end     <= res.body_end;
    end
  end

  a_end_matches_kind: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> body_end == (result_kind != KIND_PAYLOAD))
    else $error("body_end does not match result kind");

  a_payload_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_kind != KIND_PAYLOAD |-> payload_byte == 8'd0)
    else $error("payload byte set on non-payload result");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> !$past(fire))
    else $error("result register overwritten while held");

endmodule

// ===== dv/chunk_decode_checker.sv =====
`timescale 1ns / 100ps

module chunk_decode_checker import hcbd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        data_valid,
  input  logic        data_ready,
  input  logic [7:0]  data_byte,
  input  logic        result_valid,
  input  logic        result_ready,
  input  logic [1:0]  result_kind,
  input  logic [7:0]  payload_byte,
  input  logic        body_end,
  output int unsigned mismatches,
  output int unsigned outstanding,
  output int unsigned payloads_seen,
  output int unsigned bodies_seen,
  output int unsigned faults_seen
);

  typedef enum logic [2:0] {
    F_SIZE, F_EXT, F_SIZE_LF, F_DATA, F_DATA_CR, F_DATA_LF, F_LAST_CR, F_LAST_LF
  } frame_state_t;

  typedef struct {
    logic [1:0] kind;
    logic [7:0] payload;
    logic       last;
  } decoded_t;

  frame_state_t           frame = F_SIZE;
  logic [LENGTH_BITS-1:0] size_acc = '0;
  decoded_t               expected_q[$];
  decoded_t               want;
  int unsigned            fail_count = 0;
  int unsigned            n_payload = 0;
  int unsigned            n_done = 0;
  int unsigned            n_fault = 0;

  initial begin
    mismatches = 0;
    outstanding = 0;
    payloads_seen = 0;
    bodies_seen = 0;
    faults_seen = 0;
  end

  function automatic logic [3:0] hex_digit(input logic [7:0] c);
    logic [7:0] d;
    d = 8'h00;
    if (c >= "0" && c <= "9") d = c - "0";
    else if (c >= "a" && c <= "f") d = c - "a" + 8'd10;
    else if (c >= "A" && c <= "F") d = c - "A" + 8'd10;
    return d[3:0];
  endfunction

  function automatic void push_result(input logic [1:0] kind, input logic [7:0] b,
                                      input logic last);
    decoded_t r;
    r.kind = kind;
    r.payload = b;
    r.last = last;
    expected_q.push_back(r);
  endfunction

  // advances the framing state by one byte and queues what it yields
  function automatic void decode_byte(input logic [7:0] c);
    logic fault;
    fault = 1'b0;
    case (frame)
      F_SIZE: begin
        if (c == CH_CR) frame = F_SIZE_LF;
        else if (c == CH_SP) frame = F_EXT;
        else if (size_acc[LENGTH_BITS-1 -: 4] != 4'h0) fault = 1'b1;
        else size_acc = {size_acc[LENGTH_BITS-5:0], hex_digit(c)};
      end
      F_EXT: begin
        if (c == CH_CR) frame = F_SIZE_LF;
      end
      F_SIZE_LF: begin
        if (c != CH_LF) fault = 1'b1;
        else frame = (size_acc == '0) ? F_LAST_CR : F_DATA;
      end
      F_DATA: begin
        if (size_acc != '0) size_acc = size_acc - 1'b1;
        if (size_acc == '0) frame = F_DATA_CR;
        push_result(KIND_PAYLOAD, c, 1'b0);
      end
      F_DATA_CR: begin
        if (c != CH_CR) fault = 1'b1;
        else frame = F_DATA_LF;
      end
      F_DATA_LF: begin
        if (c != CH_LF) begin
          fault = 1'b1;
        end else begin
          frame = F_SIZE;
          size_acc = '0;
        end
      end
      F_LAST_CR: begin
        if (c != CH_CR) fault = 1'b1;
        else frame = F_LAST_LF;
      end
      default: begin
        if (c != CH_LF) begin
          fault = 1'b1;
        end else begin
          frame = F_SIZE;
          size_acc = '0;
          push_result(KIND_DONE, 8'h00, 1'b1);
        end
      end
    endcase
    if (fault) begin
      frame = F_SIZE;
      size_acc = '0;
      push_result(KIND_ERROR, 8'h00, 1'b1);
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      frame = F_SIZE;
      size_acc = '0;
      expected_q.delete();
    end else begin
      if (data_valid && data_ready) decode_byte(data_byte);
      if (result_valid && result_ready) begin
        if (expected_q.size() == 0) begin
          $error("result_kind: expected no transaction, got %0d", result_kind);
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          if (result_kind !== want.kind) begin
            $error("result_kind: expected %0d, got %0d", want.kind, result_kind);
            fail_count++;
          end
          if (payload_byte !== want.payload) begin
            $error("payload_byte: expected %02h, got %02h", want.payload, payload_byte);
            fail_count++;
          end
          if (body_end !== want.last) begin
            $error("body_end: expected %0d, got %0d", want.last, body_end);
            fail_count++;
          end
          case (want.kind)
            KIND_PAYLOAD: n_payload++;
            KIND_DONE:    n_done++;
            default:      n_fault++;
          endcase
        end
      end
    end
    // published through nonblocking assignments so the stimulus side never races the update
    outstanding <= expected_q.size();
    mismatches <= fail_count;
    payloads_seen <= n_payload;
    bodies_seen <= n_done;
    faults_seen <= n_fault;
  end

endmodule

// ===== dv/http_chunked_body_decoder_top_test.sv =====
`timescale 1ns / 100ps

module http_chunked_body_decoder_top_test;
  import hcbd_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned PHASE_BYTES  = 200;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       data_valid = 1'b0;
  logic [7:0] data_byte = 8'h00;
  logic       result_ready = 1'b0;
  logic       data_ready;
  logic       result_valid;
  logic [1:0] result_kind;
  logic [7:0] payload_byte;
  logic       body_end;

  int unsigned mismatches;
  int unsigned in_flight;
  int unsigned payloads_seen;
  int unsigned bodies_seen;
  int unsigned faults_seen;

  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned bytes_sent = 0;
  int unsigned cycle_count = 0;
  int unsigned idle_plan[4] = '{0, 65, 0, 18};
  int unsigned stall_plan[4] = '{0, 0, 65, 18};

  logic [7:0]  body_q[$];
  // positions of length digits and delimiters, the bytes a broken body may damage
  int unsigned frame_pos[$];

  always #10 clk = ~clk;

  http_chunked_body_decoder_top uut (
    .clk          (clk),
    .rst          (rst),
    .data_valid   (data_valid),
    .data_ready   (data_ready),
    .data_byte    (data_byte),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_kind  (result_kind),
    .payload_byte (payload_byte),
    .body_end     (body_end)
  );

  chunk_decode_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .data_valid    (data_valid),
    .data_ready    (data_ready),
    .data_byte     (data_byte),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .result_kind   (result_kind),
    .payload_byte  (payload_byte),
    .body_end      (body_end),
    .mismatches    (mismatches),
    .outstanding   (in_flight),
    .payloads_seen (payloads_seen),
    .bodies_seen   (bodies_seen),
    .faults_seen   (faults_seen)
  );

  always @(posedge clk) begin
    result_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timed out after %0d cycles with %0d results pending", cycle_count, in_flight);
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    if ($urandom_range(99) < send_idle_pct) begin
      data_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    data_valid <= 1'b1;
    data_byte <= b;
    @(posedge clk);
    while (!data_ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_all();
    foreach (body_q[i]) send_byte(body_q[i]);
    body_q.delete();
    frame_pos.delete();
  endtask

  function automatic void add_text(input string s);
    for (int i = 0; i < s.len(); i++) body_q.push_back(s[i]);
  endfunction

  // moves hex digits, CR and space out of the way so damaged framing cannot
  // turn payload into a huge chunk length
  function automatic logic [7:0] scrub(input logic [7:0] c);
    if ((c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F") ||
        c == CH_CR || c == CH_SP) return c ^ 8'h80;
    return c;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n, input bit upper);
    if (n < 4'd10) return "0" + n;
    return (upper ? "A" : "a") + n - 8'd10;
  endfunction

  function automatic void add_chunk(input int unsigned len, input bit broken);
    logic [3:0]  nibbles[$];
    int unsigned rest;
    bit          upper;
    logic [7:0]  c;
    rest = len;
    upper = 1'($urandom_range(1));
    do begin
      nibbles.push_front(rest[3:0]);
      rest = rest >> 4;
    end while (rest != 0);
    repeat ($urandom_range(2)) nibbles.push_front(4'h0);
    foreach (nibbles[i]) begin
      frame_pos.push_back(body_q.size());
      body_q.push_back(hex_char(nibbles[i], upper));
    end
    if ($urandom_range(3) == 0) begin
      body_q.push_back(CH_SP);
      repeat ($urandom_range(4)) begin
        c = 8'($urandom_range(255));
        if (broken) c = scrub(c);
        else if (c == CH_CR) c = "x";
        body_q.push_back(c);
      end
    end
    body_q.push_back(CH_CR);
    frame_pos.push_back(body_q.size());
    body_q.push_back(CH_LF);
    repeat (len) begin
      c = 8'($urandom_range(255));
      body_q.push_back(broken ? scrub(c) : c);
    end
    frame_pos.push_back(body_q.size());
    body_q.push_back(CH_CR);
    frame_pos.push_back(body_q.size());
    body_q.push_back(CH_LF);
  endfunction

  function automatic void add_body(input bit broken);
    int unsigned pick;
    int unsigned spot;
    repeat ($urandom_range(3)) begin
      pick = $urandom_range(99);
      if (pick < 80) add_chunk($urandom_range(1, 8), broken);
      else if (pick < 97) add_chunk($urandom_range(9, 40), broken);
      else add_chunk($urandom_range(100, 255), broken);
    end
    add_chunk(0, broken);
    if (broken) begin
      spot = frame_pos[$urandom_range(frame_pos.size() - 1)];
      body_q[spot] = scrub(8'($urandom_range(255)));
    end
  endfunction

  // nine digits with a nonzero lead always overflow on the last one
  function automatic void add_overflow();
    body_q.push_back(hex_char(4'($urandom_range(1, 15)), 1'($urandom_range(1))));
    repeat (8) body_q.push_back(hex_char(4'($urandom_range(15)), 1'($urandom_range(1))));
    add_text("\r\n\r\n");
  endfunction

  initial begin
    int unsigned target;
    int unsigned pick;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // non-hex digit then an extension: zero-length chunk and completion
    add_text("g 1\r\n\r\n");
    add_text("2\r\n");
    body_q.push_back(8'h00);
    body_q.push_back(8'hFF);
    add_text("\r\n");
    add_text("100000000");
    // missing LF after the length line
    add_text("\rx");
    send_all();

    for (int p = 0; p < 4; p++) begin
      send_idle_pct = idle_plan[p];
      stall_pct <= stall_plan[p];
      target = bytes_sent + PHASE_BYTES;
      while (bytes_sent < target) begin
        pick = $urandom_range(99);
        if (pick < 5) add_overflow();
        else add_body(pick >= 80);
        send_all();
      end
    end
    data_valid <= 1'b0;

    @(posedge clk);
    while (in_flight != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d body bytes over four gap/stall mixes", bytes_sent);
    $display("checked %0d payload bytes, %0d completed bodies, %0d framing errors",
             payloads_seen, bodies_seen, faults_seen);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== http_chunked_body_decoder_top.f =====
hdl/hcbd_pkg.sv
hdl/hcbd_step.sv
hdl/http_chunked_body_decoder_top.sv
dv/chunk_decode_checker.sv
dv/http_chunked_body_decoder_top_test.sv
